// File: rtl/ir_pulse_byte_receiver_assert.svh
// ---------------------------------------------------------------------------
// IR pulse byte receiver assertion macros
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef IR_PULSE_BYTE_RECEIVER_ASSERT_SVH
`define IR_PULSE_BYTE_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define IRPBR_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define IRPBR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define IRPBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define IRPBR_ASSERT_HOLDS(lbl, cond, msg)
`define IRPBR_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define IRPBR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/irpbr_pkg.sv
// ---------------------------------------------------------------------------
// IR pulse byte receiver package
// Field widths, status codes, reset timing and shared item types.
// ---------------------------------------------------------------------------
`default_nettype none

package irpbr_pkg;

   localparam int MESSAGE_BYTES_DEF = 12;
   localparam int ADC_BITS_DEF      = 10;

   localparam int COUNT_W  = 16;
   localparam int ADC_W    = 10;
   localparam int PERIOD_W = 13;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 4;
   localparam int DATA_W   = 8;
   localparam int HALF_W   = PERIOD_W - 1;
   localparam int LIMIT_W  = PERIOD_W + 4;
   localparam int RECIP_W  = 16;
   localparam int PROD_W   = COUNT_W + RECIP_W;
   localparam int SLOT_W   = 3;
   localparam int SLOT_FULL_W = 8;

   localparam int FRAC_BITS    = 16;
   localparam int RECIP_ONE    = 1 << FRAC_BITS;
   localparam int WINDOW_SLOTS = 9;
   localparam int SLOT_MAX     = 7;
   localparam int PERIOD_MIN   = 2;

   localparam int NUM_W     = FRAC_BITS + 1;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam int PERIOD_RESET_I = 269;
   localparam int HALF_RESET_I   = PERIOD_RESET_I / 2;
   localparam int LIMIT_RESET_I  = PERIOD_RESET_I * WINDOW_SLOTS + HALF_RESET_I;
   localparam int RECIP_RESET_I  = ((RECIP_ONE + PERIOD_RESET_I - 1) / PERIOD_RESET_I) % RECIP_ONE;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(PERIOD_RESET_I);
   localparam logic [HALF_W-1:0]   HALF_RESET   = HALF_W'(HALF_RESET_I);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(LIMIT_RESET_I);
   localparam logic [RECIP_W-1:0]  RECIP_RESET  = RECIP_W'(RECIP_RESET_I);

   localparam logic KIND_PULSE   = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   localparam logic [STATUS_W-1:0] ST_START     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BIT       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABORT     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COLLISION = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HEADER_OK = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STORED    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd6;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [HALF_W-1:0]  half;
      logic [LIMIT_W-1:0] limit;
      logic [RECIP_W-1:0] recip;
   } irpbr_timing_type;

   typedef struct packed {
      logic              kind;
      logic              abort;
      logic              is_bit;
      logic [SLOT_W-1:0] slot;
      logic [ADC_W-1:0]  adc;
   } irpbr_item_type;

endpackage

`default_nettype wire

// File: rtl/irpbr_recip.sv
// ---------------------------------------------------------------------------
// IR pulse byte receiver bit period unit
// Holds the bit period and derives half period, frame limit and the
// reciprocal with a one-bit-per-cycle restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module irpbr_recip
   import irpbr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [PERIOD_W-1:0] csr_bit_period,
   output      logic                busy,
   output      irpbr_timing_type    timing
);

   logic [PERIOD_W-1:0] period_ff;
   logic [HALF_W-1:0]   half_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [RECIP_W-1:0]  quot_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [PERIOD_W-1:0] rem_ff;
   logic [STEP_W-1:0]   step_ff;

   logic [PERIOD_W-1:0] period_in;
   logic [HALF_W-1:0]   half_in;
   logic [PERIOD_W:0]   rem_shift;
   logic                fits;
   logic                load;

   assign busy      = (step_ff != '0);
   assign csr_ready = !busy;
   assign load      = csr_valid && csr_ready;

   always_comb begin
      if (csr_bit_period < PERIOD_W'(PERIOD_MIN)) begin
         period_in = PERIOD_W'(PERIOD_MIN);
      end else begin
         period_in = csr_bit_period;
      end
      half_in   = period_in[PERIOD_W-1:1];
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      fits      = (rem_shift >= {1'b0, period_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         half_ff   <= HALF_RESET;
         limit_ff  <= LIMIT_RESET;
         quot_ff   <= RECIP_RESET;
         step_ff   <= '0;
      end else if (load) begin
         period_ff <= period_in;
         half_ff   <= half_in;
         limit_ff  <= LIMIT_W'({period_in, 3'b000}) + LIMIT_W'(period_in) + LIMIT_W'(half_in);
         step_ff   <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
         quot_ff <= {quot_ff[RECIP_W-2:0], fits};
         step_ff <= step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= NUM_W'(RECIP_ONE) + NUM_W'(period_in) - NUM_W'(1);
         rem_ff <= '0;
      end else if (busy) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         if (fits) begin
            rem_ff <= PERIOD_W'(rem_shift - {1'b0, period_ff});
         end else begin
            rem_ff <= rem_shift[PERIOD_W-1:0];
         end
      end
   end

   assign timing.half  = half_ff;
   assign timing.limit = limit_ff;
   assign timing.recip = quot_ff;

endmodule

`default_nettype wire

// File: rtl/irpbr_front.sv
// ---------------------------------------------------------------------------
// IR pulse byte receiver front end
// Accepts an item, checks the frame window and finds the bit slot by
// reciprocal multiply, then hands the classified item to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module irpbr_front
   import irpbr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_kind,
   input  wire logic [COUNT_W-1:0] req_timer_count,
   input  wire logic [ADC_W-1:0]   req_adc_sample,
   input  wire logic               timing_busy,
   input  wire irpbr_timing_type   timing,
   output      logic               item_valid,
   input  wire logic               item_ready,
   output      irpbr_item_type     item
);

   localparam logic [1:0] STAGE_IDLE = 2'd0;
   localparam logic [1:0] STAGE_CALC = 2'd1;
   localparam logic [1:0] STAGE_MUL  = 2'd2;
   localparam logic [1:0] STAGE_SEND = 2'd3;

   logic [1:0]         stage_ff;
   logic [1:0]         stage_in;
   logic               kind_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [ADC_W-1:0]   adc_ff;
   logic               abort_ff;
   logic               abort_in;
   logic [COUNT_W-1:0] diff_ff;
   logic [COUNT_W-1:0] diff_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [COUNT_W-1:0] half_ext;

   assign req_ready  = (stage_ff == STAGE_IDLE) && !timing_busy;
   assign item_valid = (stage_ff == STAGE_SEND);

   always_comb begin
      half_ext = COUNT_W'(timing.half);
      abort_in = (count_ff <= half_ext) || ({1'b0, count_ff} >= timing.limit);
      diff_in  = count_ff - half_ext;
      prod_in  = PROD_W'(diff_ff) * PROD_W'(timing.recip);
      stage_in = stage_ff;
      case (stage_ff)
         STAGE_IDLE: begin
            if (req_valid && req_ready) begin
               stage_in = STAGE_CALC;
            end
         end
         STAGE_CALC: stage_in = STAGE_MUL;
         STAGE_MUL:  stage_in = STAGE_SEND;
         STAGE_SEND: begin
            if (item_ready) begin
               stage_in = STAGE_IDLE;
            end
         end
         default: stage_in = STAGE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STAGE_IDLE;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff  <= req_kind;
         count_ff <= req_timer_count;
         adc_ff   <= req_adc_sample;
      end
      if (stage_ff == STAGE_CALC) begin
         abort_ff <= abort_in;
         diff_ff  <= diff_in;
      end
      if (stage_ff == STAGE_MUL) begin
         prod_ff <= prod_in;
      end
   end

   assign item.kind   = kind_ff;
   assign item.abort  = abort_ff;
   assign item.is_bit = (prod_ff[FRAC_BITS+SLOT_W +: SLOT_FULL_W-SLOT_W] == '0);
   assign item.slot   = prod_ff[FRAC_BITS +: SLOT_W];
   assign item.adc    = adc_ff;

endmodule

`default_nettype wire

// File: rtl/irpbr_queue.sv
// ---------------------------------------------------------------------------
// IR pulse byte receiver item queue
// Short first-in first-out buffer between front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module irpbr_queue
   import irpbr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output      logic           push_ready,
   input  wire irpbr_item_type push_item,
   output      logic           pop_valid,
   input  wire logic           pop_ready,
   output      irpbr_item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   irpbr_item_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              push;
   logic              pop;

   assign push_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/irpbr_back.sv
// ---------------------------------------------------------------------------
// IR pulse byte receiver back end
// Applies classified items to the reception state and registers results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ir_pulse_byte_receiver_assert.svh"

module irpbr_back
   import irpbr_pkg::*;
#(
   parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   output      logic                item_ready,
   input  wire irpbr_item_type      item,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic                rsp_busy_res,
   output      logic                rsp_low_gain_select,
   output      logic                rsp_timer_running,
   output      logic [POS_W-1:0]    rsp_byte_position,
   output      logic [DATA_W-1:0]   rsp_byte_data,
   output      logic [ADC_W-1:0]    rsp_high_gain_level,
   output      logic [ADC_W-1:0]    rsp_low_gain_level,
   output      logic                rsp_last
);

   localparam int CNT_W = $clog2(MESSAGE_BYTES + 1);

   logic                await_ff,     await_in;
   logic                in_header_ff, in_header_in;
   logic                receiving_ff, receiving_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [DATA_W-1:0]   accum_ff,     accum_in;
   logic [ADC_BITS-1:0] hg_ff,        hg_in;
   logic [ADC_BITS-1:0] lg_ff,        lg_in;
   logic                lgon_ff,      lgon_in;
   logic                timer_ff,     timer_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff,  status_in;
   logic                rsp_busy_res_ff;
   logic                rsp_lgon_ff;
   logic                rsp_timer_ff;
   logic [POS_W-1:0]    rsp_pos_ff,     pos_in;
   logic [DATA_W-1:0]   rsp_data_ff,    data_in;
   logic [ADC_W-1:0]    rsp_hg_ff;
   logic [ADC_W-1:0]    rsp_lg_ff;
   logic                rsp_last_ff,    last_in;

   logic                      pop;
   logic [ADC_BITS+ADC_W-1:0] adc_wide;
   logic [ADC_BITS-1:0]       adc_val;
   logic [CNT_W+POS_W-1:0]    pos_wide;
   logic [CNT_W-1:0]          count_next;
   logic [ADC_BITS+ADC_W-1:0] hg_wide;
   logic [ADC_BITS+ADC_W-1:0] lg_wide;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      adc_wide     = {{ADC_BITS{1'b0}}, item.adc};
      adc_val      = adc_wide[ADC_BITS-1:0];
      pos_wide     = {{POS_W{1'b0}}, count_ff};
      count_next   = count_ff + 1'b1;
      await_in     = await_ff;
      in_header_in = in_header_ff;
      receiving_in = receiving_ff;
      count_in     = count_ff;
      accum_in     = accum_ff;
      hg_in        = hg_ff;
      lg_in        = lg_ff;
      lgon_in      = lgon_ff;
      timer_in     = timer_ff;
      status_in    = ST_START;
      pos_in       = '0;
      data_in      = '0;
      last_in      = 1'b0;
      if (item.kind == KIND_TIMEOUT) begin
         timer_in     = 1'b0;
         await_in     = 1'b1;
         in_header_in = 1'b1;
         receiving_in = 1'b0;
         lgon_in      = 1'b0;
         status_in    = ST_TIMEOUT;
      end else begin
         receiving_in = 1'b1;
         if (await_ff) begin
            timer_in = 1'b1;
            accum_in = '0;
            await_in = 1'b0;
            if (in_header_ff) begin
               hg_in   = adc_val;
               lgon_in = 1'b1;
            end
            status_in = ST_START;
         end else if (item.abort) begin
            timer_in     = 1'b0;
            await_in     = 1'b1;
            in_header_in = 1'b1;
            receiving_in = 1'b0;
            lgon_in      = 1'b0;
            status_in    = ST_ABORT;
         end else if (item.is_bit) begin
            accum_in  = accum_ff | (DATA_W'(1) << item.slot);
            status_in = ST_BIT;
         end else begin
            await_in = 1'b1;
            if (in_header_ff) begin
               lg_in   = adc_val;
               lgon_in = 1'b0;
               if (accum_ff != '0) begin
                  timer_in     = 1'b0;
                  in_header_in = 1'b1;
                  receiving_in = 1'b0;
                  status_in    = ST_COLLISION;
               end else begin
                  in_header_in = 1'b0;
                  count_in     = '0;
                  status_in    = ST_HEADER_OK;
               end
            end else begin
               pos_in  = pos_wide[POS_W-1:0];
               data_in = accum_ff;
               if (count_next >= CNT_W'(MESSAGE_BYTES)) begin
                  timer_in     = 1'b0;
                  await_in     = 1'b1;
                  in_header_in = 1'b1;
                  receiving_in = 1'b0;
                  lgon_in      = 1'b0;
                  count_in     = '0;
                  status_in    = ST_DONE;
                  last_in      = 1'b1;
               end else begin
                  count_in  = count_next;
                  status_in = ST_STORED;
               end
            end
         end
      end
      hg_wide = {{ADC_W{1'b0}}, hg_in};
      lg_wide = {{ADC_W{1'b0}}, lg_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff     <= 1'b1;
         in_header_ff <= 1'b1;
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         accum_ff     <= '0;
         hg_ff        <= '0;
         lg_ff        <= '0;
         lgon_ff      <= 1'b0;
         timer_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            await_ff     <= await_in;
            in_header_ff <= in_header_in;
            receiving_ff <= receiving_in;
            count_ff     <= count_in;
            accum_ff     <= accum_in;
            hg_ff        <= hg_in;
            lg_ff        <= lg_in;
            lgon_ff      <= lgon_in;
            timer_ff     <= timer_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_status_ff   <= status_in;
         rsp_busy_res_ff <= receiving_in;
         rsp_lgon_ff     <= lgon_in;
         rsp_timer_ff    <= timer_in;
         rsp_pos_ff      <= pos_in;
         rsp_data_ff     <= data_in;
         rsp_hg_ff       <= hg_wide[ADC_W-1:0];
         rsp_lg_ff       <= lg_wide[ADC_W-1:0];
         rsp_last_ff     <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_busy_res        = rsp_busy_res_ff;
   assign rsp_low_gain_select = rsp_lgon_ff;
   assign rsp_timer_running   = rsp_timer_ff;
   assign rsp_byte_position   = rsp_pos_ff;
   assign rsp_byte_data       = rsp_data_ff;
   assign rsp_high_gain_level = rsp_hg_ff;
   assign rsp_low_gain_level  = rsp_lg_ff;
   assign rsp_last            = rsp_last_ff;

   `IRPBR_ASSERT_IMPLIES(a_timer_needs_rx, timer_ff, receiving_ff, "timer armed while idle")
   `IRPBR_ASSERT_IMPLIES(a_low_gain_in_header, lgon_ff, in_header_ff && receiving_ff, "low gain outside header")
   `IRPBR_ASSERT_HOLDS(a_count_range, count_ff < CNT_W'(MESSAGE_BYTES), "byte count out of range")
   `IRPBR_ASSERT_NEXT(a_pop_loads_out, pop, rsp_valid_ff, "popped item produced no result")
   `IRPBR_ASSERT_IMPLIES(a_done_closes, rsp_valid_ff && rsp_status_ff == ST_DONE, !rsp_busy_res_ff && !rsp_timer_ff && rsp_last_ff, "message done left reception open")

endmodule

`default_nettype wire

// File: rtl/ir_pulse_byte_receiver.sv
// ---------------------------------------------------------------------------
// IR pulse byte receiver
// Decodes pulse-position IR frames into header status and message bytes.
// ---------------------------------------------------------------------------
// Each req item is a pulse edge (bit timer count and converter sample) or a
// receive timeout, and gives exactly one rsp item. The front end takes one
// item at a time, through capture, frame window check, 16x16 reciprocal
// multiply for the bit slot and hand-off into a two-entry queue, and takes
// the next only after that hand-off; the back end updates the reception
// state and loads the output register in the same cycle. A waiting result
// holds the next queued item back until rsp_ready. A write of bit_period runs
// a one-bit-per-cycle reciprocal divider, during which req_ready and csr_ready
// are low. After reset the block is ready at once, with the reset bit period.
`default_nettype none

module ir_pulse_byte_receiver
   import irpbr_pkg::*;
#(
   parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_kind,
   input  wire logic [COUNT_W-1:0]  req_timer_count,
   input  wire logic [ADC_W-1:0]    req_adc_sample,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic                rsp_busy_res,
   output      logic                rsp_low_gain_select,
   output      logic                rsp_timer_running,
   output      logic [POS_W-1:0]    rsp_byte_position,
   output      logic [DATA_W-1:0]   rsp_byte_data,
   output      logic [ADC_W-1:0]    rsp_high_gain_level,
   output      logic [ADC_W-1:0]    rsp_low_gain_level,
   output      logic                rsp_last,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [PERIOD_W-1:0] csr_bit_period
);

   irpbr_timing_type timing;
   logic             timing_busy;
   logic             push_valid;
   logic             push_ready;
   irpbr_item_type   push_item;
   logic             pop_valid;
   logic             pop_ready;
   irpbr_item_type   pop_item;

   irpbr_recip u_recip (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_bit_period (csr_bit_period),
      .busy           (timing_busy),
      .timing         (timing)
   );

   irpbr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_timer_count (req_timer_count),
      .req_adc_sample  (req_adc_sample),
      .timing_busy     (timing_busy),
      .timing          (timing),
      .item_valid      (push_valid),
      .item_ready      (push_ready),
      .item            (push_item)
   );

   irpbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   irpbr_back #(
      .MESSAGE_BYTES (MESSAGE_BYTES),
      .ADC_BITS      (ADC_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (pop_valid),
      .item_ready          (pop_ready),
      .item                (pop_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_low_gain_select (rsp_low_gain_select),
      .rsp_timer_running   (rsp_timer_running),
      .rsp_byte_position   (rsp_byte_position),
      .rsp_byte_data       (rsp_byte_data),
      .rsp_high_gain_level (rsp_high_gain_level),
      .rsp_low_gain_level  (rsp_low_gain_level),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire
